// ----- rtl/pngu_pkg.sv -----
// Shared types, codes and sizes of the PNG scanline unfilter.
package pngu_pkg;

  localparam int DEF_MAX_ROW_BYTES   = 8192;
  localparam int DEF_MAX_PIXEL_BYTES = 8;
  localparam int IN_Q_DEPTH          = 4;
  localparam int OUT_Q_DEPTH         = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [1:0] REG_PIXEL_BYTES = 2'd1;
  localparam logic [1:0] REG_ROW_COUNT   = 2'd2;

  // Filter type codes as they appear in the stream
  localparam logic [7:0] FTYPE_SUB   = 8'd1;
  localparam logic [7:0] FTYPE_UP    = 8'd2;
  localparam logic [7:0] FTYPE_AVG   = 8'd3;
  localparam logic [7:0] FTYPE_PAETH = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } filt_t;

  // Per-byte control that travels from front to back
  typedef struct packed {
    filt_t filt;
    logic  first_row;
    logic  row_end;
    logic  image_end;
  } ctl_t;

  // Map a filter type byte to its operation; unknown types pass data through.
  function automatic filt_t classify(input logic [7:0] code);
    filt_t f;
    case (code)
      FTYPE_SUB:   f = FILT_SUB;
      FTYPE_UP:    f = FILT_UP;
      FTYPE_AVG:   f = FILT_AVG;
      FTYPE_PAETH: f = FILT_PAETH;
      default:     f = FILT_NONE;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/pngu_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
module pngu_fifo
  import pngu_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pngu_front.sv -----
// Front end: splits filter bytes from data bytes and tracks row/column position.
module pngu_front
  import pngu_pkg::*;
#(
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
  parameter int COL_W         = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_push,
  input  logic [7:0]       in_byte,
  input  logic [13:0]      row_bytes,
  input  logic [15:0]      row_count,
  input  logic             q_full,
  output logic             q_push,
  output logic [7:0]       q_byte,
  output ctl_t             q_ctl,
  output logic [COL_W-1:0] q_col
);

  logic             await_filter;
  logic             await_filter_next;
  filt_t            row_filter;
  filt_t            row_filter_next;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [15:0]      row_idx;
  logic [15:0]      row_idx_next;
  logic             accept;
  logic [31:0]      len_eff;
  logic [31:0]      rows_eff;
  logic             last_col;
  logic             last_row;

  always_comb begin
    if (row_bytes == '0) begin
      len_eff = 32'd1;
    end else if (32'(row_bytes) > 32'(MAX_ROW_BYTES)) begin
      len_eff = 32'(MAX_ROW_BYTES);
    end else begin
      len_eff = 32'(row_bytes);
    end
    rows_eff = (row_count == '0) ? 32'd1 : 32'(row_count);
  end

  assign accept   = in_push && !q_full;
  assign last_col = (32'(col) + 32'd1) >= len_eff;
  assign last_row = (32'(row_idx) + 32'd1) >= rows_eff;

  assign q_push          = accept && !await_filter;
  assign q_byte          = in_byte;
  assign q_col           = col;
  assign q_ctl.filt      = row_filter;
  assign q_ctl.first_row = (row_idx == '0);
  assign q_ctl.row_end   = last_col;
  assign q_ctl.image_end = last_col && last_row;

  always_comb begin
    await_filter_next = await_filter;
    row_filter_next   = row_filter;
    col_next          = col;
    row_idx_next      = row_idx;
    if (accept) begin
      if (await_filter) begin
        row_filter_next   = classify(in_byte);
        col_next          = '0;
        await_filter_next = 1'b0;
      end else if (last_col) begin
        col_next          = '0;
        await_filter_next = 1'b1;
        row_idx_next      = last_row ? '0 : row_idx + 16'd1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      await_filter <= 1'b1;
      row_filter   <= FILT_NONE;
      col          <= '0;
      row_idx      <= '0;
    end else begin
      await_filter <= await_filter_next;
      row_filter   <= row_filter_next;
      col          <= col_next;
      row_idx      <= row_idx_next;
    end
  end

endmodule

// ----- rtl/pngu_back.sv -----
// Back end: prior-row memory, neighbor history and the reconstruction filters.
module pngu_back
  import pngu_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
  parameter int COL_W           = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       pb_eff,
  input  logic             q_empty,
  input  logic [7:0]       q_byte,
  input  ctl_t             q_ctl,
  input  logic [COL_W-1:0] q_col,
  output logic             q_pop,
  input  logic             out_full,
  output logic             out_push,
  output logic [7:0]       out_byte,
  output logic             out_row_end,
  output logic             out_image_end
);

  localparam int PIX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [7:0]       prior_row [MAX_ROW_BYTES];
  logic [7:0]       left_hist [MAX_PIXEL_BYTES];
  logic [7:0]       up_hist   [MAX_PIXEL_BYTES];

  logic             s1_valid;
  logic [7:0]       s1_byte;
  ctl_t             s1_ctl;
  logic [COL_W-1:0] s1_col;
  logic [7:0]       mem_q;
  logic             fwd_hit;
  logic [7:0]       fwd_data;

  logic             advance;
  logic [PIX_W-1:0] pix_idx;
  logic [7:0]       a;
  logic [7:0]       b;
  logic [7:0]       c;
  logic [8:0]       avg_sum;
  logic [7:0]       pred;
  logic [7:0]       r;

  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [7:0]         sel;
    p  = $signed({3'b000, pa_a}) + $signed({3'b000, pa_b}) - $signed({3'b000, pa_c});
    da = p - $signed({3'b000, pa_a});
    db = p - $signed({3'b000, pa_b});
    dc = p - $signed({3'b000, pa_c});
    da = (da < 0) ? -da : da;
    db = (db < 0) ? -db : db;
    dc = (dc < 0) ? -dc : dc;
    if (da <= db && da <= dc) begin
      sel = pa_a;
    end else if (db <= dc) begin
      sel = pa_b;
    end else begin
      sel = pa_c;
    end
    return sel;
  endfunction

  assign advance = s1_valid && !out_full;
  assign q_pop   = !q_empty && (!s1_valid || advance);
  assign pix_idx = PIX_W'(pb_eff - 4'd1);

  always_comb begin
    b = s1_ctl.first_row ? 8'd0 : (fwd_hit ? fwd_data : mem_q);
    if (32'(s1_col) >= 32'(pb_eff)) begin
      a = left_hist[pix_idx];
      c = up_hist[pix_idx];
    end else begin
      a = 8'd0;
      c = 8'd0;
    end
    avg_sum = {1'b0, a} + {1'b0, b};
    case (s1_ctl.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    r = s1_byte + pred;
  end

  assign out_push      = advance;
  assign out_byte      = r;
  assign out_row_end   = s1_ctl.row_end;
  assign out_image_end = s1_ctl.image_end;

  // Prior-row memory: write the finished byte, read the next item's up neighbor.
  always_ff @(posedge clk) begin
    if (advance) begin
      prior_row[s1_col] <= r;
    end
    if (q_pop) begin
      mem_q <= prior_row[q_col];
    end
  end

  // Bypass a write that lands on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      fwd_hit  <= advance && (s1_col == q_col);
      fwd_data <= r;
      s1_byte  <= q_byte;
      s1_ctl   <= q_ctl;
      s1_col   <= q_col;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist[i] <= left_hist[i-1];
        up_hist[i]   <= up_hist[i-1];
      end
      left_hist[0] <= r;
      up_hist[0]   <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/png_scanline_unfilter.sv -----
// PNG scanline unfilter top level: configuration, queues, front and back ends.
//
// Usage: the filtered image enters one byte per request on push/data_byte,
// taken at an edge with push high and full low. Every row starts with its
// filter type byte (None, Sub, Up, Average, Paeth; other codes pass data
// through), followed by row_bytes data bytes. The filter byte gives no
// result; each data byte gives one reconstructed pixel_byte with row_end
// on the last byte of a row and image_end on the last byte of the last row.
// Results wait on pixel_byte/row_end/image_end while empty is low; pop takes
// one. After the last byte of the last row the block expects a new image.
// Configuration: cfg_valid/cfg_index/cfg_data, cfg_ready always high;
// index 0 row_bytes, 1 pixel_bytes, 2 row_count. Write only while idle.
// A taken data byte is registered in the input queue, then in the back end's
// reconstruction stage, then in the output queue. One byte per cycle while
// not stalled, set by that single stage's left-neighbor history feedback.
// Reset (rst, synchronous) empties both queues, clears position state and
// sets all three registers to 1. When the receiver stalls, results collect
// in the output queue, then the back end holds, then the four-entry input
// queue fills and full rises; nothing is dropped.
module png_scanline_unfilter
  import pngu_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  data_byte,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  pixel_byte,
  output logic        row_end,
  output logic        image_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int IQ_W  = 8 + $bits(ctl_t) + COL_W;
  localparam int OQ_W  = 10;

  logic [13:0]      row_bytes;
  logic [3:0]       pixel_bytes;
  logic [15:0]      row_count;
  logic [3:0]       pb_eff;

  // front -> input queue
  logic             fq_push;
  logic [7:0]       fq_byte;
  ctl_t             fq_ctl;
  logic [COL_W-1:0] fq_col;
  logic             iq_full;
  logic             iq_empty;
  logic             iq_pop;
  logic [IQ_W-1:0]  iq_rdata;
  logic [7:0]       bq_byte;
  ctl_t             bq_ctl;
  logic [COL_W-1:0] bq_col;

  // back -> output queue
  logic             oq_full;
  logic             oq_push;
  logic [7:0]       ob_byte;
  logic             ob_row_end;
  logic             ob_image_end;
  logic [OQ_W-1:0]  oq_rdata;

  // Configuration registers: always ready, unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= 14'd1;
      pixel_bytes <= 4'd1;
      row_count   <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_BYTES:   row_bytes   <= cfg_data[13:0];
        REG_PIXEL_BYTES: pixel_bytes <= cfg_data[3:0];
        REG_ROW_COUNT:   row_count   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Pixel size 0 acts as 1, sizes above the history depth are clamped.
  always_comb begin
    if (pixel_bytes == '0) begin
      pb_eff = 4'd1;
    end else if (32'(pixel_bytes) > 32'(MAX_PIXEL_BYTES)) begin
      pb_eff = 4'(MAX_PIXEL_BYTES);
    end else begin
      pb_eff = pixel_bytes;
    end
  end

  assign full = iq_full;

  pngu_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .COL_W         (COL_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_push   (push),
    .in_byte   (data_byte),
    .row_bytes (row_bytes),
    .row_count (row_count),
    .q_full    (iq_full),
    .q_push    (fq_push),
    .q_byte    (fq_byte),
    .q_ctl     (fq_ctl),
    .q_col     (fq_col)
  );

  pngu_fifo #(
    .WIDTH (IQ_W),
    .DEPTH (IN_Q_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata ({fq_byte, fq_ctl, fq_col}),
    .full  (iq_full),
    .pop   (iq_pop),
    .rdata (iq_rdata),
    .empty (iq_empty)
  );

  assign {bq_byte, bq_ctl, bq_col} = iq_rdata;

  pngu_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .COL_W           (COL_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pb_eff        (pb_eff),
    .q_empty       (iq_empty),
    .q_byte        (bq_byte),
    .q_ctl         (bq_ctl),
    .q_col         (bq_col),
    .q_pop         (iq_pop),
    .out_full      (oq_full),
    .out_push      (oq_push),
    .out_byte      (ob_byte),
    .out_row_end   (ob_row_end),
    .out_image_end (ob_image_end)
  );

  pngu_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata ({ob_byte, ob_row_end, ob_image_end}),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign {pixel_byte, row_end, image_end} = oq_rdata;

`ifndef SYNTH
  // The last byte of an image always closes a row.
  a_image_end_row_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && image_end) |-> row_end)
    else $error("image_end without row_end");

  // The back end never presents a result the output queue cannot take.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> !oq_full)
    else $error("output queue overflow");

  // The front end only forwards a data byte while the input queue has room.
  a_in_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fq_push |-> (push && !iq_full))
    else $error("input queue push without request");

  // A popped input request is in the back end's stage in the next cycle.
  a_pop_loads_stage: assert property (@(posedge clk) disable iff (rst)
    iq_pop |=> u_back.s1_valid)
    else $error("back stage not loaded after pop");
`endif

endmodule
